FILE: sv/tagged_section_rom_loader_defines.svh
// Assertion macros for the tagged section ROM loader.
// Each one is empty when SYNTHESIS is defined.
`ifndef TAGGED_SECTION_ROM_LOADER_DEFINES_SVH
`define TAGGED_SECTION_ROM_LOADER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is low.
`define TSRL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define TSRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSRL_ASSERT(label, clk, rst_n, prop, msg)
`define TSRL_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: sv/tsrl_pkg.sv
package tsrl_pkg;

  // Default ROM limits in bytes
  localparam int unsigned KEY_BYTES_DEF     = 11;
  localparam int unsigned PROGRAM_BYTES_DEF = 262144;
  localparam int unsigned SAMPLE_BYTES_DEF  = 8388608;

  // Section header layout
  localparam int unsigned HDR_LEN = 11;
  localparam int unsigned TAG_LEN = 3;

  // Fixed field widths
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned ADDR_W      = 23;
  localparam int unsigned PROG_SIZE_W = 19;
  localparam int unsigned SAMP_SIZE_W = 24;
  localparam int unsigned HCNT_W      = 4;

  // Section tags, ASCII
  localparam logic [23:0] TAG_KEY = 24'h4B4559;
  localparam logic [23:0] TAG_Z80 = 24'h5A3830;
  localparam logic [23:0] TAG_SMP = 24'h534D50;

  typedef enum logic [1:0] {
    ROM_KEY     = 2'd0,
    ROM_PROGRAM = 2'd1,
    ROM_SAMPLE  = 2'd2
  } rom_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN_TAG  = 3'd1,
    ST_BEYOND_LIMIT = 3'd2,
    ST_TRUNCATED    = 3'd3,
    ST_NO_PROGRAM   = 3'd4
  } status_e;

  typedef struct packed {
    logic                   write_valid;
    rom_e                   rom_select;
    logic [ADDR_W-1:0]      write_address;
    logic [DATA_W-1:0]      write_data;
    status_e                status;
    logic                   load_done;
    logic                   key_present;
    logic [PROG_SIZE_W-1:0] program_size;
    logic [SAMP_SIZE_W-1:0] sample_size;
  } res_t;

endpackage

FILE: sv/tsrl_in_if.sv
interface tsrl_in_if;
  import tsrl_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              image_last;
  logic              load_first;
  logic              load_last;

  modport source (
    output valid, data_byte, image_last, load_first, load_last,
    input  ready
  );

  modport sink (
    input  valid, data_byte, image_last, load_first, load_last,
    output ready
  );
endinterface

FILE: sv/tsrl_out_if.sv
interface tsrl_out_if;
  import tsrl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   write_valid;
  logic [1:0]             rom_select;
  logic [ADDR_W-1:0]      write_address;
  logic [DATA_W-1:0]      write_data;
  logic [2:0]             status;
  logic                   load_done;
  logic                   key_present;
  logic [PROG_SIZE_W-1:0] program_size;
  logic [SAMP_SIZE_W-1:0] sample_size;

  modport source (
    output valid, write_valid, rom_select, write_address, write_data, status,
           load_done, key_present, program_size, sample_size,
    input  ready
  );

  modport sink (
    input  valid, write_valid, rom_select, write_address, write_data, status,
           load_done, key_present, program_size, sample_size,
    output ready
  );
endinterface

FILE: sv/tagged_section_rom_loader.sv
// Tagged section ROM loader.
// byte_i carries program images one byte per transfer, with image_last,
// load_first and load_last marks. Each image is a run of 11-byte section
// headers (3-byte tag, LE offset, LE length) each followed by its payload.
// result_o gives exactly one result per input byte: a ROM write when the
// byte is payload, the sticky status, load_done and the running ROM sizes.
// A result is registered in the output register, or in the skid entry
// while another waits. One byte is taken per cycle while byte_i.ready is
// high; all parsing and size tracking is one registered step, the deepest
// path being the 33-bit offset plus length add and its limit compare.
// Reset clears the parser, sizes and status, and empties the output.
// The output side has a result register plus one skid entry, so a byte is
// still taken while one result waits; byte_i.ready drops only when both
// entries are full, and rises again in the cycle after result_o takes one.
// Bytes after a fault are ignored until load_first; image ends, load_last
// and load_done keep working.
`include "tagged_section_rom_loader_defines.svh"

module tagged_section_rom_loader #(
  parameter int unsigned KEY_BYTES         = tsrl_pkg::KEY_BYTES_DEF,
  parameter int unsigned PROGRAM_ROM_BYTES = tsrl_pkg::PROGRAM_BYTES_DEF,
  parameter int unsigned SAMPLE_ROM_BYTES  = tsrl_pkg::SAMPLE_BYTES_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  tsrl_in_if.sink      byte_i,
  tsrl_out_if.source   result_o
);
  import tsrl_pkg::*;

  // Size register widths follow the ROM limits
  localparam int unsigned KSZ_W = $clog2(KEY_BYTES + 1);
  localparam int unsigned PSZ_W = $clog2(PROGRAM_ROM_BYTES + 1);
  localparam int unsigned SSZ_W = $clog2(SAMPLE_ROM_BYTES + 1);
  localparam int unsigned MAX_W = (PSZ_W > KSZ_W) ? PSZ_W : KSZ_W;
  // A live section never runs past its limit, so its length fits here
  localparam int unsigned LEN_W = (SSZ_W > MAX_W) ? SSZ_W : MAX_W;
  localparam int unsigned HDR_W = 8 * (HDR_LEN - TAG_LEN - 1);

  localparam logic [32:0] KeyLimit  = 33'(KEY_BYTES);
  localparam logic [32:0] ProgLimit = 33'(PROGRAM_ROM_BYTES);
  localparam logic [32:0] SampLimit = 33'(SAMPLE_ROM_BYTES);

  // Parser state
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic              pay_q, pay_d;
  logic [23:0]       tag_q, tag_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;   // upper header bytes, oldest at bottom
  rom_e              rom_q, rom_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [LEN_W-1:0]  left_q, left_d;
  // ROM sizes and sticky status
  logic [KSZ_W-1:0]  ksz_q, ksz_d;
  logic [PSZ_W-1:0]  psz_q, psz_d;
  logic [SSZ_W-1:0]  ssz_q, ssz_d;
  status_e           err_q, err_d;

  // Output register and skid entry
  res_t out_q, out_d, skid_q, skid_d, res_new;
  logic out_v_q, out_v_d, skid_v_q, skid_v_d;

  logic        push, pop, img_end;
  logic [63:0] hdr_full;
  logic [31:0] offset, length;
  logic [32:0] sec_end, limit, cur_size;
  logic        tag_ok;
  rom_e        sec_rom;

  assign push    = byte_i.valid & byte_i.ready;
  assign pop     = out_v_q & result_o.ready;
  assign img_end = byte_i.image_last | byte_i.load_last;

  // Header fields as they stand once the current byte is shifted in
  assign hdr_full = {byte_i.data_byte, hdr_q};
  assign offset   = hdr_full[31:0];
  assign length   = hdr_full[63:32];
  assign sec_end  = {1'b0, offset} + {1'b0, length};

  always_comb begin
    tag_ok   = 1'b1;
    sec_rom  = ROM_KEY;
    limit    = KeyLimit;
    cur_size = 33'(ksz_q);
    case (tag_q)
      TAG_KEY: begin
        sec_rom  = ROM_KEY;
        limit    = KeyLimit;
        cur_size = 33'(ksz_q);
      end
      TAG_Z80: begin
        sec_rom  = ROM_PROGRAM;
        limit    = ProgLimit;
        cur_size = 33'(psz_q);
      end
      TAG_SMP: begin
        sec_rom  = ROM_SAMPLE;
        limit    = SampLimit;
        cur_size = 33'(ssz_q);
      end
      default: tag_ok = 1'b0;
    endcase
  end

  // One byte step
  always_comb begin
    hcnt_d = hcnt_q;
    pay_d  = pay_q;
    tag_d  = tag_q;
    hdr_d  = hdr_q;
    rom_d  = rom_q;
    addr_d = addr_q;
    left_d = left_q;
    ksz_d  = ksz_q;
    psz_d  = psz_q;
    ssz_d  = ssz_q;
    err_d  = err_q;

    res_new               = '0;
    res_new.rom_select    = ROM_KEY;

    // load_first starts from the reset state; tag, header and section
    // registers are always rewritten before they are used again
    if (byte_i.load_first) begin
      hcnt_d = '0;
      pay_d  = 1'b0;
      ksz_d  = '0;
      psz_d  = '0;
      ssz_d  = '0;
      err_d  = ST_OK;
    end

    if (err_d == ST_OK) begin
      if (pay_d) begin
        res_new.write_valid   = 1'b1;
        res_new.rom_select    = rom_q;
        res_new.write_address = addr_q;
        res_new.write_data    = byte_i.data_byte;
        addr_d = addr_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == LEN_W'(1)) begin
          pay_d  = 1'b0;
          hcnt_d = '0;
        end
      end else begin
        if (hcnt_d < HCNT_W'(TAG_LEN)) begin
          tag_d = {tag_q[15:0], byte_i.data_byte};
        end else begin
          hdr_d = hdr_full[63:8];
        end
        hcnt_d = hcnt_d + 1'b1;
        // last header byte: check and open the section
        if (hcnt_d >= HCNT_W'(HDR_LEN)) begin
          hcnt_d = '0;
          if (!tag_ok) begin
            err_d = ST_UNKNOWN_TAG;
          end else if (sec_end > limit) begin
            err_d = ST_BEYOND_LIMIT;
          end else begin
            if (sec_end > cur_size) begin
              case (sec_rom)
                ROM_KEY:     ksz_d = KSZ_W'(sec_end);
                ROM_PROGRAM: psz_d = PSZ_W'(sec_end);
                ROM_SAMPLE:  ssz_d = SSZ_W'(sec_end);
                default:     ksz_d = KSZ_W'(sec_end);
              endcase
            end
            if (length != '0) begin
              pay_d  = 1'b1;
              rom_d  = sec_rom;
              addr_d = offset[ADDR_W-1:0];
              left_d = length[LEN_W-1:0];
            end
          end
        end
      end
    end

    if (img_end) begin
      if (err_d == ST_OK && pay_d) begin
        err_d = ST_TRUNCATED;
      end
      hcnt_d = '0;
      pay_d  = 1'b0;
    end

    if (byte_i.load_last && err_d == ST_OK && psz_d == '0) begin
      err_d = ST_NO_PROGRAM;
    end

    res_new.status       = err_d;
    res_new.load_done    = byte_i.load_last;
    res_new.key_present  = (ksz_d == KSZ_W'(KEY_BYTES));
    res_new.program_size = PROG_SIZE_W'(psz_d);
    res_new.sample_size  = SAMP_SIZE_W'(ssz_d);
  end

  // Output register plus skid entry
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = res_new;
        skid_v_d = push;
      end else begin
        out_d    = res_new;
        out_v_d  = push;
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      skid_d   = res_new;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q   <= '0;
      pay_q    <= 1'b0;
      ksz_q    <= '0;
      psz_q    <= '0;
      ssz_q    <= '0;
      err_q    <= ST_OK;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (push) begin
        hcnt_q <= hcnt_d;
        pay_q  <= pay_d;
        ksz_q  <= ksz_d;
        psz_q  <= psz_d;
        ssz_q  <= ssz_d;
        err_q  <= err_d;
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      tag_q  <= tag_d;
      hdr_q  <= hdr_d;
      rom_q  <= rom_d;
      addr_q <= addr_d;
      left_q <= left_d;
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign byte_i.ready = ~skid_v_q;

  assign result_o.valid         = out_v_q;
  assign result_o.write_valid   = out_q.write_valid;
  assign result_o.rom_select    = out_q.rom_select;
  assign result_o.write_address = out_q.write_address;
  assign result_o.write_data    = out_q.write_data;
  assign result_o.status        = out_q.status;
  assign result_o.load_done     = out_q.load_done;
  assign result_o.key_present   = out_q.key_present;
  assign result_o.program_size  = out_q.program_size;
  assign result_o.sample_size   = out_q.sample_size;

  // Skid entry only fills behind a held result
  `TSRL_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "skid valid without output")
  // An open section always has bytes left
  `TSRL_ASSERT(a_pay_has_bytes, clk_i, rst_ni, pay_q |-> (left_q != '0), "payload with zero bytes left")
  // A fault holds until the next load starts
  `TSRL_ASSERT(a_err_sticky, clk_i, rst_ni, (err_q != ST_OK && !(push && byte_i.load_first)) |=> (err_q == $past(err_q)), "sticky status changed")
  // No parser or output activity survives a reset cycle
  `TSRL_ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |=> (!out_v_q && !skid_v_q && !pay_q), "state not cleared in reset")

endmodule
